// ===== hdl/mtu_pkg.sv =====
// ----------------------------------------------------------------------------
// mtu_pkg
// Shared types and constants of the machine timer interrupt unit: request
// kinds, register offset defaults, reset values and the register select.
// ----------------------------------------------------------------------------
package mtu_pkg;

   localparam int unsigned DATA_W = 64;
   localparam int unsigned OFFSET_W = 16;
   localparam int unsigned KIND_W = 2;

   localparam logic [KIND_W-1:0] REQ_READ = 2'd0;
   localparam logic [KIND_W-1:0] REQ_WRITE = 2'd1;
   localparam logic [KIND_W-1:0] REQ_TICK = 2'd2;

   localparam logic [OFFSET_W-1:0] MSIP_OFFSET = 16'd0;
   localparam logic [OFFSET_W-1:0] MTIMECMP_OFFSET = 16'd16384;
   localparam logic [OFFSET_W-1:0] FREQ_OFFSET = 16'd32768;
   localparam logic [OFFSET_W-1:0] INC_OFFSET = 16'd32776;
   localparam logic [OFFSET_W-1:0] MTIME_OFFSET = 16'd49144;

   localparam logic [DATA_W-1:0] COMPARE_RESET = 64'd999999;

   typedef struct packed {
      logic freq;
      logic inc;
      logic mtime;
      logic msip;
      logic cmp;
   } reg_sel_type;

endpackage

// ===== hdl/mtu_decode.sv =====
// ----------------------------------------------------------------------------
// mtu_decode
// Decodes a byte offset into a one-hot register select. When two offsets
// are equal, frequency wins over increment, time, software word and compare.
// ----------------------------------------------------------------------------
module mtu_decode #(
   parameter logic [mtu_pkg::OFFSET_W-1:0] MsipOffset = mtu_pkg::MSIP_OFFSET,
   parameter logic [mtu_pkg::OFFSET_W-1:0] MtimecmpOffset = mtu_pkg::MTIMECMP_OFFSET,
   parameter logic [mtu_pkg::OFFSET_W-1:0] FreqOffset = mtu_pkg::FREQ_OFFSET,
   parameter logic [mtu_pkg::OFFSET_W-1:0] IncOffset = mtu_pkg::INC_OFFSET,
   parameter logic [mtu_pkg::OFFSET_W-1:0] MtimeOffset = mtu_pkg::MTIME_OFFSET
) (
   input  logic [mtu_pkg::OFFSET_W-1:0] reg_offset,
   output mtu_pkg::reg_sel_type         reg_sel
);

   always_comb begin
      reg_sel = '0;
      if (reg_offset == FreqOffset) begin
         reg_sel.freq = 1'b1;
      end else if (reg_offset == IncOffset) begin
         reg_sel.inc = 1'b1;
      end else if (reg_offset == MtimeOffset) begin
         reg_sel.mtime = 1'b1;
      end else if (reg_offset == MsipOffset) begin
         reg_sel.msip = 1'b1;
      end else if (reg_offset == MtimecmpOffset) begin
         reg_sel.cmp = 1'b1;
      end
   end

endmodule

// ===== hdl/mtu_core.sv =====
// ----------------------------------------------------------------------------
// mtu_core
// Timer register state. Applies one request per cycle when advance is high:
// read mux, register write, time tick and the interrupt level update.
// ----------------------------------------------------------------------------
module mtu_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [mtu_pkg::KIND_W-1:0]    req_kind,
   input  mtu_pkg::reg_sel_type          reg_sel,
   input  logic [mtu_pkg::DATA_W-1:0]    write_data,
   input  logic                          irq_enable,
   output logic [mtu_pkg::DATA_W-1:0]    read_data,
   output logic                          irq_next,
   output logic                          irq_level
);

   logic [mtu_pkg::DATA_W-1:0] freq_ff, freq_in;
   logic [mtu_pkg::DATA_W-1:0] inc_ff, inc_in;
   logic [mtu_pkg::DATA_W-1:0] time_ff, time_in;
   logic [mtu_pkg::DATA_W-1:0] msip_ff, msip_in;
   logic [mtu_pkg::DATA_W-1:0] cmp_ff, cmp_in;
   logic                       level_ff, level_in;

   always_comb begin
      freq_in = freq_ff;
      inc_in = inc_ff;
      time_in = time_ff;
      msip_in = msip_ff;
      cmp_in = cmp_ff;
      read_data = '0;
      case (req_kind)
         mtu_pkg::REQ_READ: begin
            read_data = ({mtu_pkg::DATA_W{reg_sel.freq}} & freq_ff)
                      | ({mtu_pkg::DATA_W{reg_sel.inc}} & inc_ff)
                      | ({mtu_pkg::DATA_W{reg_sel.mtime}} & time_ff)
                      | ({mtu_pkg::DATA_W{reg_sel.msip}} & msip_ff)
                      | ({mtu_pkg::DATA_W{reg_sel.cmp}} & cmp_ff);
         end
         mtu_pkg::REQ_WRITE: begin
            if (reg_sel.freq) freq_in = write_data;
            if (reg_sel.inc) inc_in = write_data;
            if (reg_sel.mtime) time_in = write_data;
            if (reg_sel.msip) msip_in = write_data;
            if (reg_sel.cmp) cmp_in = write_data;
         end
         mtu_pkg::REQ_TICK: begin
            time_in = time_ff + mtu_pkg::DATA_W'(1);
         end
         default: begin
         end
      endcase
      level_in = irq_enable ? (time_in >= cmp_in) : level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= '0;
         inc_ff <= '0;
         time_ff <= '0;
         msip_ff <= '0;
         cmp_ff <= mtu_pkg::COMPARE_RESET;
         level_ff <= 1'b0;
      end else if (advance) begin
         freq_ff <= freq_in;
         inc_ff <= inc_in;
         time_ff <= time_in;
         msip_ff <= msip_in;
         cmp_ff <= cmp_in;
         level_ff <= level_in;
      end
   end

   assign irq_next = level_in;
   assign irq_level = level_ff;

endmodule

// ===== hdl/machine_timer_interrupt_unit.sv =====
// ----------------------------------------------------------------------------
// machine_timer_interrupt_unit
// Core-local timer with frequency, increment, time, software word and
// compare registers, and a level-sensitive machine timer interrupt.
// ----------------------------------------------------------------------------
// Usage: each request on the req_ channel is a register read, a register
// write or one time tick. Every request yields exactly one response on the
// rsp_ channel, in order, carrying the read data (zero for writes, ticks and
// unknown offsets) and the timer interrupt level after that request.
// The csr_ channel writes the interrupt enable; it is always ready. The user must
// write it only while no request is in flight; the block does not enforce this.
// A request is captured in the input register, then applied to the timer
// registers and captured in the response register. Throughput is one
// request per cycle while the receiver does not stall, set by the single
// 64-bit increment and compare between those two registers.
// When the receiver stalls, the response register holds its item and the
// input register takes one more request before req_ready drops.
// Reset clears time, frequency, increment and software word, sets compare to
// 999999, clears the interrupt level, sets the enable and empties the pipe.
// ----------------------------------------------------------------------------
module machine_timer_interrupt_unit #(
   parameter logic [mtu_pkg::OFFSET_W-1:0] MsipOffset = mtu_pkg::MSIP_OFFSET,
   parameter logic [mtu_pkg::OFFSET_W-1:0] MtimecmpOffset = mtu_pkg::MTIMECMP_OFFSET,
   parameter logic [mtu_pkg::OFFSET_W-1:0] FreqOffset = mtu_pkg::FREQ_OFFSET,
   parameter logic [mtu_pkg::OFFSET_W-1:0] IncOffset = mtu_pkg::INC_OFFSET,
   parameter logic [mtu_pkg::OFFSET_W-1:0] MtimeOffset = mtu_pkg::MTIME_OFFSET
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mtu_pkg::KIND_W-1:0]    req_type,
   input  logic [mtu_pkg::OFFSET_W-1:0]  req_reg_offset,
   input  logic [mtu_pkg::DATA_W-1:0]    req_write_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mtu_pkg::DATA_W-1:0]    rsp_read_data,
   output logic                          rsp_timer_irq,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_irq_enable
);

   logic                         s1_valid_ff, s1_valid_in;
   logic [mtu_pkg::KIND_W-1:0]   s1_kind_ff;
   logic [mtu_pkg::OFFSET_W-1:0] s1_offset_ff;
   logic [mtu_pkg::DATA_W-1:0]   s1_data_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [mtu_pkg::DATA_W-1:0]   rsp_data_ff;
   logic                         rsp_irq_ff;
   logic                         enable_ff;
   logic                         out_free;
   logic                         advance;
   logic                         accept;
   mtu_pkg::reg_sel_type         reg_sel;
   logic [mtu_pkg::DATA_W-1:0]   read_data;
   logic                         irq_next;
   logic                         irq_level;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept = req_valid && req_ready;
   assign s1_valid_in = accept || (s1_valid_ff && !out_free);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         enable_ff <= 1'b1;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            enable_ff <= csr_irq_enable;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff <= req_type;
         s1_offset_ff <= req_reg_offset;
         s1_data_ff <= req_write_data;
      end
      if (advance) begin
         rsp_data_ff <= read_data;
         rsp_irq_ff <= irq_next;
      end
   end

   mtu_decode #(
      .MsipOffset(MsipOffset),
      .MtimecmpOffset(MtimecmpOffset),
      .FreqOffset(FreqOffset),
      .IncOffset(IncOffset),
      .MtimeOffset(MtimeOffset)
   ) u_decode (
      .reg_offset(s1_offset_ff),
      .reg_sel(reg_sel)
   );

   mtu_core u_core (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .req_kind(s1_kind_ff),
      .reg_sel(reg_sel),
      .write_data(s1_data_ff),
      .irq_enable(enable_ff),
      .read_data(read_data),
      .irq_next(irq_next),
      .irq_level(irq_level)
   );

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_timer_irq = rsp_irq_ff;

   a_non_read_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_kind_ff != mtu_pkg::REQ_READ) |=> rsp_read_data == '0)
      else $error("Non-read response carries nonzero read data.");

   a_disabled_level_holds: assert property (@(posedge clock) disable iff (reset)
      (advance && !enable_ff) |=> rsp_timer_irq == $past(irq_level))
      else $error("Interrupt level changed while disabled.");

   a_response_matches_level: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_timer_irq == irq_level)
      else $error("Response level differs from the stored level.");

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff))
      else $error("Request channel stalled with room in the pipe.");

endmodule

// ===== tb/machine_timer_interrupt_unit_test.sv =====
// ----------------------------------------------------------------------------
// machine_timer_interrupt_unit_test
// Drives register reads, register writes, time ticks and the unused request
// kind into the timer block with random gaps and response stalls. It predicts
// every response from its own copy of the timer registers and the interrupt
// enable, and checks the responses in order.
// ----------------------------------------------------------------------------
module machine_timer_interrupt_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mtu_pkg::*;

   localparam logic [KIND_W-1:0] REQ_IDLE = 2'd3;
   localparam int unsigned PHASE_COUNT = 5;
   localparam int unsigned PHASE_ITEMS = 140;

   typedef enum logic [2:0] {
      SEL_NONE,
      SEL_FREQ,
      SEL_INC,
      SEL_MTIME,
      SEL_MSIP,
      SEL_MTIMECMP
   } reg_select_type;

   class scoreboard_type;
      logic [DATA_W-1:0] freq_q;
      logic [DATA_W-1:0] inc_q;
      logic [DATA_W-1:0] mtime_q;
      logic [DATA_W-1:0] msip_q;
      logic [DATA_W-1:0] mtimecmp_q;
      logic irq_q;
      logic enable_q;
      logic [DATA_W-1:0] exp_read_data[$];
      logic exp_timer_irq[$];
      int unsigned errors;

      function new();
         freq_q = '0;
         inc_q = '0;
         mtime_q = '0;
         msip_q = '0;
         mtimecmp_q = COMPARE_RESET;
         irq_q = 1'b0;
         enable_q = 1'b1;
         errors = 0;
      endfunction

      function void set_enable(logic value);
         enable_q = value;
      endfunction

      // When offsets coincide, the first match in this order wins.
      function reg_select_type decode_offset(logic [OFFSET_W-1:0] offset);
         if (offset == FREQ_OFFSET) return SEL_FREQ;
         if (offset == INC_OFFSET) return SEL_INC;
         if (offset == MTIME_OFFSET) return SEL_MTIME;
         if (offset == MSIP_OFFSET) return SEL_MSIP;
         if (offset == MTIMECMP_OFFSET) return SEL_MTIMECMP;
         return SEL_NONE;
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, logic [OFFSET_W-1:0] offset,
                                 logic [DATA_W-1:0] data);
         logic [DATA_W-1:0] read_value;
         read_value = '0;
         if (kind == REQ_READ) begin
            case (decode_offset(offset))
               SEL_FREQ: read_value = freq_q;
               SEL_INC: read_value = inc_q;
               SEL_MTIME: read_value = mtime_q;
               SEL_MSIP: read_value = msip_q;
               SEL_MTIMECMP: read_value = mtimecmp_q;
               default: ;
            endcase
         end else if (kind == REQ_WRITE) begin
            case (decode_offset(offset))
               SEL_FREQ: freq_q = data;
               SEL_INC: inc_q = data;
               SEL_MTIME: mtime_q = data;
               SEL_MSIP: msip_q = data;
               SEL_MTIMECMP: mtimecmp_q = data;
               default: ;
            endcase
         end else if (kind == REQ_TICK) begin
            mtime_q = mtime_q + 64'd1;
         end
         if (enable_q) irq_q = (mtime_q >= mtimecmp_q);
         exp_read_data.push_back(read_value);
         exp_timer_irq.push_back(irq_q);
      endfunction

      function void check_response(logic [DATA_W-1:0] read_data, logic timer_irq);
         logic [DATA_W-1:0] want_data;
         logic want_irq;
         if (exp_read_data.size() == 0) begin
            $error("Response with no request outstanding: read_data %h timer_irq %b",
                   read_data, timer_irq);
            errors++;
            return;
         end
         want_data = exp_read_data.pop_front();
         want_irq = exp_timer_irq.pop_front();
         if (read_data !== want_data) begin
            $error("read_data mismatch: expected %h actual %h", want_data, read_data);
            errors++;
         end
         if (timer_irq !== want_irq) begin
            $error("timer_irq mismatch: expected %b actual %b", want_irq, timer_irq);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return exp_read_data.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [KIND_W-1:0] req_type;
   logic [OFFSET_W-1:0] req_reg_offset;
   logic [DATA_W-1:0] req_write_data;
   logic rsp_valid;
   logic rsp_ready;
   logic [DATA_W-1:0] rsp_read_data;
   logic rsp_timer_irq;
   logic csr_valid;
   logic csr_ready;
   logic csr_irq_enable;

   scoreboard_type sb;
   int unsigned rsp_count;
   int unsigned burst_left;
   bit phase_enable[PHASE_COUNT] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

   machine_timer_interrupt_unit u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_reg_offset(req_reg_offset),
      .req_write_data(req_write_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_timer_irq(rsp_timer_irq),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_irq_enable(csr_irq_enable)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_enable(csr_irq_enable);
         if (req_valid && req_ready) sb.note_request(req_type, req_reg_offset, req_write_data);
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_read_data, rsp_timer_irq);
            rsp_count++;
         end
      end
   end

   // The response side stalls in segments of varying density, and once
   // holds off long enough for the block to back up into the request side.
   initial begin
      int unsigned seg_left;
      int unsigned mode;
      int unsigned hold_left;
      bit long_hold_done;
      seg_left = 0;
      mode = 0;
      hold_left = 0;
      long_hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!long_hold_done && rsp_count >= 240) begin
            hold_left = 150;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            if (seg_left == 0) begin
               mode = $urandom_range(0, 3);
               seg_left = $urandom_range(10, 60);
            end
            seg_left--;
            case (mode)
               0: rsp_ready = 1'b1;
               1: rsp_ready = ($urandom_range(0, 99) < 80);
               2: rsp_ready = ($urandom_range(0, 99) < 40);
               default: rsp_ready = ($urandom_range(0, 99) < 10);
            endcase
         end
      end
   end

   task automatic pause_sender();
      int unsigned gap;
      int unsigned pick;
      gap = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 10) burst_left = $urandom_range(10, 40);
         else if (pick < 55) gap = 0;
         else if (pick < 92) gap = $urandom_range(1, 3);
         else gap = $urandom_range(8, 30);
      end
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_request(logic [KIND_W-1:0] kind, logic [OFFSET_W-1:0] offset,
                               logic [DATA_W-1:0] data);
      pause_sender();
      req_valid = 1'b1;
      req_type = kind;
      req_reg_offset = offset;
      req_write_data = data;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_random_request();
      logic [KIND_W-1:0] kind;
      logic [OFFSET_W-1:0] offset;
      logic [DATA_W-1:0] data;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) kind = REQ_READ;
      else if (pick < 60) kind = REQ_WRITE;
      else if (pick < 95) kind = REQ_TICK;
      else kind = REQ_IDLE;
      case ($urandom_range(0, 19))
         0, 1, 2: offset = 16'($urandom_range(0, 65535));
         3, 4, 5: offset = FREQ_OFFSET;
         6, 7, 8: offset = INC_OFFSET;
         9, 10, 11, 12: offset = MTIME_OFFSET;
         13, 14, 15: offset = MSIP_OFFSET;
         default: offset = MTIMECMP_OFFSET;
      endcase
      // Values near the current time and compare make ticks cross the compare.
      case ($urandom_range(0, 9))
         0, 1, 2, 3: data = {$urandom, $urandom};
         4, 5: data = sb.mtimecmp_q + 64'($urandom_range(0, 6)) - 64'd3;
         6: data = sb.mtime_q + 64'($urandom_range(0, 6)) - 64'd3;
         7: data = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 4));
         8: data = '0;
         default: data = 64'($urandom_range(0, 1000));
      endcase
      send_request(kind, offset, data);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_irq_enable(logic value);
      csr_valid = 1'b1;
      csr_irq_enable = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      #10ms;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_READ;
      req_reg_offset = '0;
      req_write_data = '0;
      csr_valid = 1'b0;
      csr_irq_enable = 1'b0;
      rsp_count = 0;
      burst_left = 0;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_irq_enable(1'b1);
      send_request(REQ_READ, MSIP_OFFSET, '0);
      send_request(REQ_READ, MTIMECMP_OFFSET, '0);
      send_request(REQ_READ, FREQ_OFFSET, '0);
      send_request(REQ_READ, INC_OFFSET, '0);
      send_request(REQ_READ, MTIME_OFFSET, '0);
      send_request(REQ_WRITE, FREQ_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(REQ_READ, FREQ_OFFSET, '0);
      send_request(REQ_WRITE, INC_OFFSET, 64'h5555_AAAA_5555_AAAA);
      send_request(REQ_READ, INC_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(REQ_WRITE, MSIP_OFFSET, 64'hAAAA_5555_AAAA_5555);
      send_request(REQ_READ, MSIP_OFFSET, '0);
      send_request(REQ_WRITE, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(REQ_READ, 16'hFFFF, '0);
      send_request(REQ_READ, 16'h0008, '0);
      send_request(REQ_WRITE, MTIME_OFFSET, 64'd999998);
      send_request(REQ_TICK, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(REQ_IDLE, MTIME_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(REQ_WRITE, MTIMECMP_OFFSET, '0);
      send_request(REQ_WRITE, MTIMECMP_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(REQ_WRITE, MTIME_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(REQ_TICK, FREQ_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(REQ_TICK, MTIME_OFFSET, '0);
      send_request(REQ_READ, MTIME_OFFSET, '0);
      send_request(REQ_READ, MTIMECMP_OFFSET, '0);
      send_request(REQ_IDLE, 16'hFFFF, '0);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_drained();
         write_irq_enable(phase_enable[phase]);
         repeat (PHASE_ITEMS) send_random_request();
      end
      wait_drained();

      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
